// ===== sv/gregorian_date_add_days_core_macros.svh =====
// Assertion macros shared by the date adder RTL.
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_MACROS_SVH

`ifndef SYNTH

// Antecedent implies consequent in the same cycle.
`define GDAD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdad assertion failed");

// Antecedent implies consequent in the next cycle.
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdad assertion failed");

`else

`define GDAD_ASSERT_NOW(label, clk, rst, ante, cons)
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/gdad_pkg.sv =====
// Types, constants, microcode ROM and calendar helpers for the date adder.
package gdad_pkg;

   localparam int YEAR_BITS     = 14;
   localparam int ADD_DAYS_BITS = 16;
   localparam int MONTH_BITS    = 4;
   localparam int DAY_BITS      = 5;
   // day accumulator holds day + add_days before month rollover
   localparam int ACC_BITS      = ADD_DAYS_BITS + 1;
   localparam int MOD25_BITS    = 5;
   localparam int UPC_BITS      = 3;

   localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

   // year / 25 by reciprocal: q = (year * RECIP_25) >> RECIP_SHIFT, may be one low
   localparam int RECIP_BITS  = 12;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_BITS   = YEAR_BITS + RECIP_BITS;
   localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
   localparam logic [RECIP_BITS-1:0] RECIP_25 = 12'd2621;
   localparam logic [5:0]            DIV_25   = 6'd25;
   localparam logic [MOD25_BITS-1:0] MOD25_TOP = 5'd24;

   localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_BITS-1:0]   DAY_LAST  = 5'd31;

   // microcode step addresses
   localparam logic [UPC_BITS-1:0] STEP_IDLE  = 3'd0;
   localparam logic [UPC_BITS-1:0] STEP_MUL   = 3'd1;
   localparam logic [UPC_BITS-1:0] STEP_MOD   = 3'd2;
   localparam logic [UPC_BITS-1:0] STEP_CHECK = 3'd3;
   localparam logic [UPC_BITS-1:0] STEP_LOOP  = 3'd4;
   localparam logic [UPC_BITS-1:0] STEP_EMIT  = 3'd5;
   localparam logic [UPC_BITS-1:0] STEP_WRAP  = 3'd6;

   typedef struct packed {
      logic [YEAR_BITS-1:0]     year;
      logic [MONTH_BITS-1:0]    month;
      logic [DAY_BITS-1:0]      day;
      logic [ADD_DAYS_BITS-1:0] add_days;
   } req_type;

   typedef struct packed {
      logic [YEAR_BITS-1:0]  result_year;
      logic [MONTH_BITS-1:0] result_month;
      logic [DAY_BITS-1:0]   result_day;
      logic                  input_valid;
      logic                  year_overflow;
   } rsp_type;

   // datapath operation of one control word
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_MOD,
      OP_CHECK,
      OP_STEP,
      OP_EMIT
   } op_type;

   // jump condition of one control word
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_INVALID,
      C_STEPPING,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type               op;
      cond_type             cond;
      logic [UPC_BITS-1:0]  target;
   } uword_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic no_req;
      logic invalid;
      logic stepping;
      logic out_busy;
   } cond_flags_type;

   // control store: jump to target when cond holds, else fall through
   function automatic uword_type ucode(input logic [UPC_BITS-1:0] upc);
      uword_type w;
      unique case (upc)
         STEP_IDLE:  w = uword_type'{op: OP_LOAD,  cond: C_NO_REQ,   target: STEP_IDLE};
         STEP_MUL:   w = uword_type'{op: OP_MUL,   cond: C_NEVER,    target: STEP_IDLE};
         STEP_MOD:   w = uword_type'{op: OP_MOD,   cond: C_NEVER,    target: STEP_IDLE};
         STEP_CHECK: w = uword_type'{op: OP_CHECK, cond: C_INVALID,  target: STEP_EMIT};
         STEP_LOOP:  w = uword_type'{op: OP_STEP,  cond: C_STEPPING, target: STEP_LOOP};
         STEP_EMIT:  w = uword_type'{op: OP_EMIT,  cond: C_OUT_BUSY, target: STEP_EMIT};
         STEP_WRAP:  w = uword_type'{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_IDLE};
         default:    w = uword_type'{op: OP_NOP,   cond: C_ALWAYS,   target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // leap: div by 4 and (not div by 25, or div by 16)
   function automatic logic is_leap(input logic [YEAR_BITS-1:0]  year,
                                    input logic [MOD25_BITS-1:0] mod25);
      return (year[1:0] == 2'd0) && ((mod25 != '0) || (year[3:0] == 4'd0));
   endfunction

   // month length, zero for an illegal month code
   function automatic logic [DAY_BITS-1:0] month_days(input logic [MONTH_BITS-1:0] month,
                                                      input logic                  leap);
      logic [DAY_BITS-1:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== sv/gdad_useq.sv =====
// Microcode sequencer: step counter, control store and conditional jump.
module gdad_useq (
   input  logic                        clock,
   input  logic                        reset,
   input  gdad_pkg::cond_flags_type    flags,
   output gdad_pkg::uword_type         uword
);

   logic [gdad_pkg::UPC_BITS-1:0] upc_ff;
   logic [gdad_pkg::UPC_BITS-1:0] upc_in;
   logic                          taken;

   assign uword = gdad_pkg::ucode(upc_ff);

   // jump condition decode
   always_comb begin
      unique case (uword.cond)
         gdad_pkg::C_NEVER:    taken = 1'b0;
         gdad_pkg::C_ALWAYS:   taken = 1'b1;
         gdad_pkg::C_NO_REQ:   taken = flags.no_req;
         gdad_pkg::C_INVALID:  taken = flags.invalid;
         gdad_pkg::C_STEPPING: taken = flags.stepping;
         gdad_pkg::C_OUT_BUSY: taken = flags.out_busy;
         default:              taken = 1'b1;
      endcase
      upc_in = taken ? uword.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= gdad_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== sv/gregorian_date_add_days_core.sv =====
// Top level: Gregorian date plus day count, microcoded month-stepping datapath.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  req_data (year, month, day, add_days)
//   rsp      out  rsp_valid / rsp_ready  rsp_data (result date, valid, overflow)
//
// A transaction steps through load, multiply, mod 25, check, the month loop, emit and wrap;
// the month loop retires one month per cycle, up to about 2160 month ends for the largest count.
// An illegal start date skips the month loop.
// Reset clears the step counter and the output valid; payload registers are not reset.
// A result waits in the output register while the next transaction is loaded and run;
// the sequencer only stalls in its emit step if that register is still full and not being taken.
`include "gregorian_date_add_days_core_macros.svh"

module gregorian_date_add_days_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gdad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gdad_pkg::rsp_type rsp_data
);

   gdad_pkg::uword_type      uword;
   gdad_pkg::cond_flags_type flags;

   logic [gdad_pkg::YEAR_BITS-1:0]     year_ff,  year_in;
   logic [gdad_pkg::MONTH_BITS-1:0]    month_ff, month_in;
   logic [gdad_pkg::ACC_BITS-1:0]      day_ff,   day_in;
   logic [gdad_pkg::ADD_DAYS_BITS-1:0] add_ff,   add_in;
   logic [gdad_pkg::PROD_BITS-1:0]     prod_ff,  prod_in;
   logic [gdad_pkg::MOD25_BITS-1:0]    mod25_ff, mod25_in;
   logic                               valid_ff, valid_in;
   logic                               ovf_ff,   ovf_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   gdad_pkg::rsp_type                  rsp_ff,   rsp_in;

   logic                               accept;
   logic                               emit;
   logic                               leap;
   logic [gdad_pkg::DAY_BITS-1:0]      len;
   logic                               fits;
   logic                               last_day_stop;
   logic [gdad_pkg::QUOT_BITS-1:0]     quot;
   logic [gdad_pkg::YEAR_BITS-1:0]     rem_wide;
   logic [5:0]                         rem;
   logic [gdad_pkg::MOD25_BITS-1:0]    mod25_calc;

   gdad_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .uword (uword)
   );

   // handshake
   assign req_ready = (uword.op == gdad_pkg::OP_LOAD);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // calendar status of the working date
   assign leap          = gdad_pkg::is_leap(year_ff, mod25_ff);
   assign len           = gdad_pkg::month_days(month_ff, leap);
   assign fits          = (day_ff <= gdad_pkg::ACC_BITS'(len));
   assign last_day_stop = (month_ff == gdad_pkg::MONTH_DEC) && (year_ff == gdad_pkg::YEAR_MAX);

   assign flags.no_req   = ~req_valid;
   assign flags.invalid  = (len == '0) | (day_ff == '0) | ~fits;
   assign flags.stepping = ~fits & ~last_day_stop;
   assign flags.out_busy = rsp_valid_ff & ~rsp_ready;

   assign emit = (uword.op == gdad_pkg::OP_EMIT) & ~flags.out_busy;

   // year mod 25 from the registered reciprocal product, one correction
   always_comb begin
      quot       = prod_ff[gdad_pkg::PROD_BITS-1:gdad_pkg::RECIP_SHIFT];
      rem_wide   = year_ff - gdad_pkg::YEAR_BITS'(quot * gdad_pkg::DIV_25);
      rem        = rem_wide[5:0];
      mod25_calc = (rem >= gdad_pkg::DIV_25) ? gdad_pkg::MOD25_BITS'(rem - gdad_pkg::DIV_25)
                                             : gdad_pkg::MOD25_BITS'(rem);
   end

   // datapath next state, one operation per control word
   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      add_in   = add_ff;
      prod_in  = prod_ff;
      mod25_in = mod25_ff;
      valid_in = valid_ff;
      ovf_in   = ovf_ff;
      case (uword.op)
         gdad_pkg::OP_LOAD: begin
            if (accept) begin
               year_in  = req_data.year;
               month_in = req_data.month;
               day_in   = gdad_pkg::ACC_BITS'(req_data.day);
               add_in   = req_data.add_days;
               valid_in = 1'b1;
               ovf_in   = 1'b0;
            end
         end
         gdad_pkg::OP_MUL: begin
            prod_in = gdad_pkg::PROD_BITS'(year_ff) * gdad_pkg::PROD_BITS'(gdad_pkg::RECIP_25);
         end
         gdad_pkg::OP_MOD: begin
            mod25_in = mod25_calc;
         end
         gdad_pkg::OP_CHECK: begin
            if (flags.invalid) begin
               year_in  = '0;
               month_in = '0;
               day_in   = '0;
               valid_in = 1'b0;
            end else begin
               day_in = day_ff + gdad_pkg::ACC_BITS'(add_ff);
            end
         end
         gdad_pkg::OP_STEP: begin
            if (!fits) begin
               if (last_day_stop) begin
                  // clamp at the last representable day
                  month_in = gdad_pkg::MONTH_DEC;
                  day_in   = gdad_pkg::ACC_BITS'(gdad_pkg::DAY_LAST);
                  ovf_in   = 1'b1;
               end else begin
                  day_in = day_ff - gdad_pkg::ACC_BITS'(len);
                  if (month_ff == gdad_pkg::MONTH_DEC) begin
                     year_in  = year_ff + 1'b1;
                     month_in = gdad_pkg::MONTH_JAN;
                     mod25_in = (mod25_ff == gdad_pkg::MOD25_TOP) ? '0 : mod25_ff + 1'b1;
                  end else begin
                     month_in = month_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_in.result_year   = year_ff;
         rsp_in.result_month  = month_ff;
         rsp_in.result_day    = day_ff[gdad_pkg::DAY_BITS-1:0];
         rsp_in.input_valid   = valid_ff;
         rsp_in.year_overflow = ovf_ff;
         rsp_valid_in         = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      add_ff   <= add_in;
      prod_ff  <= prod_in;
      mod25_ff <= mod25_in;
      valid_ff <= valid_in;
      ovf_ff   <= ovf_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `GDAD_ASSERT_NEXT(a_load_leaves_idle, clock, reset, accept, !req_ready)
   `GDAD_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !rsp_data.input_valid,
      (rsp_data.result_year == '0) && (rsp_data.result_month == '0) &&
      (rsp_data.result_day == '0) && !rsp_data.year_overflow)
   `GDAD_ASSERT_NOW(a_valid_range, clock, reset, rsp_valid && rsp_data.input_valid,
      (rsp_data.result_month >= gdad_pkg::MONTH_JAN) &&
      (rsp_data.result_month <= gdad_pkg::MONTH_DEC) && (rsp_data.result_day != '0))
   `GDAD_ASSERT_NOW(a_ovf_clamp, clock, reset, rsp_valid && rsp_data.year_overflow,
      (rsp_data.result_year == gdad_pkg::YEAR_MAX) &&
      (rsp_data.result_month == gdad_pkg::MONTH_DEC) &&
      (rsp_data.result_day == gdad_pkg::DAY_LAST))

endmodule
